// ===== hdl/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP streamer package
// Shared word types, result kinds and controller command codes.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH    = 240;
  localparam int unsigned DEF_SCREEN_HEIGHT   = 320;
  localparam int unsigned DEF_COLUMN_OFFSET   = 0;
  localparam int unsigned DEF_ROW_OFFSET      = 0;
  localparam int unsigned DEF_MAX_IMAGE_WIDTH = 1280;

  localparam logic [3:0] QUEUE_DEPTH_LOG2 = 4'd4;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [15:0] CMD_HADDR = 16'h0046;
  localparam logic [15:0] CMD_VEND  = 16'h0048;
  localparam logic [15:0] CMD_VSTA  = 16'h0047;
  localparam logic [15:0] CMD_XADDR = 16'h0020;
  localparam logic [15:0] CMD_YADDR = 16'h0021;
  localparam logic [15:0] CMD_WRAM  = 16'h0022;

  localparam logic [4:0] HDR_OFFSET_END = 5'd13;
  localparam logic [4:0] HDR_WIDTH_END  = 5'd21;
  localparam logic [4:0] HDR_HEIGHT_END = 5'd25;
  localparam logic [4:0] HDR_PLANES_END = 5'd27;
  localparam logic [4:0] HDR_DEPTH_END  = 5'd29;
  localparam logic [5:0] HDR_LAST       = 6'd33;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word_value;
    logic        last;
  } out_word_t;

  // Classified work handed from the parser to the emitter.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_WINDOW = 2'd1,
    OP_PIXEL  = 2'd2
  } op_code_t;

  typedef struct packed {
    op_code_t    op;
    logic        flag;
    logic [15:0] val_a;
    logic [15:0] val_b;
    logic [15:0] val_c;
  } op_t;

endpackage

// ===== hdl/bmp_parse.sv =====
// ----------------------------------------------------------------------------
// BMP streamer front end
// Parses the file header and pixel bytes and issues status, window and pixel operations.
// ----------------------------------------------------------------------------
module bmp_parse import bmp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int unsigned COLUMN_OFFSET   = DEF_COLUMN_OFFSET,
  parameter int unsigned ROW_OFFSET      = DEF_ROW_OFFSET,
  parameter int unsigned MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_word_t in_word,
  output logic     op_valid,
  output op_t      op
);

  localparam logic [31:0] SW  = 32'(SCREEN_WIDTH);
  localparam logic [31:0] SH  = 32'(SCREEN_HEIGHT);
  localparam logic [31:0] MW  = 32'(MAX_IMAGE_WIDTH);
  localparam logic [15:0] CO  = 16'(COLUMN_OFFSET);
  localparam logic [15:0] RO  = 16'(ROW_OFFSET);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_BAD  = 6'b000100,
    PH_WAIT = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  phase_t      phase;
  logic [31:0] byte_pos;
  logic [31:0] offset;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [31:0] scratch;
  logic [31:0] skip_rows;
  logic [8:0]  row;
  logic [13:0] byte_in_row;
  logic [1:0]  cphase;
  logic [15:0] acc;
  logic [7:0]  xs;
  logic [7:0]  xe;
  logic [8:0]  ys;
  logic [13:0] row_bytes;
  logic [9:0]  vis_bytes;

  logic [31:0] pos;
  logic [31:0] scr_next;
  logic        bad;
  logic [31:0] xs_c;
  logic [31:0] xe_c;
  logic [31:0] ys_c;
  logic [31:0] ye_c;
  logic [31:0] vis_w;
  logic [14:0] k1;
  logic        fin;
  logic [15:0] pix;

  // Header scratch shift and header field checks.
  always_comb begin
    pos      = in_word.file_start ? 32'd0 : byte_pos;
    scr_next = ((in_word.file_start ? 32'd0 : scratch) >> 8) | {in_word.data_byte, 24'd0};
    bad = (phase == PH_BAD) || (scr_next != 32'd0) || (img_w == 32'd0) || (img_w > MW) ||
          (img_h == 32'd0) || (offset < 32'd34);
    if (img_w > SW) begin
      xs_c = 32'd0;
      xe_c = SW - 32'd1;
    end else begin
      xs_c = (SW - img_w) >> 1;
      xe_c = xs_c + img_w - 32'd1;
    end
    if (img_h > SH) begin
      ys_c = 32'd0;
      ye_c = SH - 32'd1;
    end else begin
      ys_c = (SH - img_h) >> 1;
      ye_c = ys_c + img_h - 32'd1;
    end
    vis_w = (img_w > SW) ? SW : img_w;
    k1    = {1'b0, byte_in_row} + 15'd1;
    fin   = (row == ys) && (k1 == {5'd0, vis_bytes});
    pix   = acc | {in_word.data_byte[7:3], 11'd0};
  end

  // Main parser sequence.
  always_ff @(posedge clk) begin
    op_valid <= 1'b0;
    if (rst) begin
      phase     <= PH_IDLE;
      byte_pos  <= 32'd0;
      scratch   <= 32'd0;
      offset    <= 32'd0;
      img_w     <= 32'd0;
      img_h     <= 32'd0;
      skip_rows <= 32'd0;
      row       <= 9'd0;
      byte_in_row <= 14'd0;
      cphase    <= 2'd0;
      acc       <= 16'd0;
      xs <= 8'd0;
      xe <= 8'd0;
      ys <= 9'd0;
      row_bytes <= 14'd0;
      vis_bytes <= 10'd0;
    end else if (in_valid) begin
      if (in_word.file_start || (phase != PH_IDLE && phase != PH_DONE)) begin
        byte_pos <= (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
      end
      if (in_word.file_start || phase == PH_HDR || phase == PH_BAD) begin
        scratch <= scr_next;
        if (in_word.file_start) begin
          phase <= PH_HDR;
        end
        if (pos == 32'(HDR_OFFSET_END)) begin
          offset <= scr_next;
        end else if (pos == 32'(HDR_WIDTH_END)) begin
          img_w <= scr_next;
        end else if (pos == 32'(HDR_HEIGHT_END)) begin
          img_h <= scr_next;
        end else if (pos == 32'(HDR_PLANES_END)) begin
          if (scr_next[31:16] != 16'd1) begin
            phase <= PH_BAD;
          end
        end else if (pos == 32'(HDR_DEPTH_END)) begin
          if (scr_next[31:16] != 16'd24) begin
            phase <= PH_BAD;
          end
        end else if (pos == 32'(HDR_LAST)) begin
          op_valid <= 1'b1;
          op.op    <= OP_STATUS;
          op.flag  <= bad;
          op.val_a <= 16'd0;
          op.val_b <= 16'd0;
          op.val_c <= 16'd0;
          if (bad) begin
            phase <= PH_DONE;
          end else begin
            phase <= PH_WAIT;
            xs <= xs_c[7:0];
            xe <= xe_c[7:0];
            ys <= ys_c[8:0];
            row <= ye_c[8:0];
            skip_rows <= (img_h > SH) ? img_h - SH : 32'd0;
            byte_in_row <= 14'd0;
            cphase <= 2'd0;
            acc <= 16'd0;
            row_bytes <= 14'((img_w * 32'd3 + 32'd3) & ~32'd3);
            vis_bytes <= 10'(vis_w * 32'd3);
          end
        end
      end else if ((phase == PH_WAIT && pos == offset) || phase == PH_DATA) begin
        phase <= PH_DATA;
        if (skip_rows == 32'd0) begin
          // A row start issues the window operation; every third visible byte a pixel.
          op.val_a <= {CO[7:0] + xe, 8'd0} | (CO + {8'd0, xs});
          op.val_b <= RO + {7'd0, row};
          op.val_c <= CO + {8'd0, xs};
          op.op    <= (byte_in_row == 14'd0) ? OP_WINDOW : OP_PIXEL;
          op.flag  <= 1'b0;
          op_valid <= (byte_in_row == 14'd0);
          if (byte_in_row < {4'd0, vis_bytes}) begin
            if (byte_in_row == 14'd0 || cphase == 2'd0) begin
              acc    <= {11'd0, in_word.data_byte[7:3]};
              cphase <= 2'd1;
            end else if (cphase == 2'd1) begin
              acc    <= acc | {5'd0, in_word.data_byte[7:2], 5'd0};
              cphase <= 2'd2;
            end else begin
              cphase   <= 2'd0;
              op_valid <= 1'b1;
              op.flag  <= fin;
              op.val_a <= pix;
              if (fin) begin
                phase <= PH_DONE;
              end
            end
          end
        end
        if (!(skip_rows == 32'd0 && byte_in_row < {4'd0, vis_bytes} &&
              byte_in_row != 14'd0 && cphase == 2'd2 && fin)) begin
          if (k1 >= {1'b0, row_bytes}) begin
            byte_in_row <= 14'd0;
            if (skip_rows != 32'd0) begin
              skip_rows <= skip_rows - 32'd1;
            end else if (row > ys) begin
              row <= row - 9'd1;
            end else begin
              phase <= PH_DONE;
            end
          end else begin
            byte_in_row <= k1[13:0];
          end
        end
      end
    end
  end

endmodule

// ===== hdl/bmp_emit.sv =====
// ----------------------------------------------------------------------------
// BMP streamer back end
// Queues parser operations and expands each into output words.
// ----------------------------------------------------------------------------
module bmp_emit import bmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  input  op_t       op,
  output logic      full,
  output logic      empty,
  output out_word_t result,
  input  logic      pop
);

  localparam int unsigned DEPTH = 1 << QUEUE_DEPTH_LOG2;

  op_t                       mem [DEPTH];
  logic [QUEUE_DEPTH_LOG2-1:0] wr_ptr;
  logic [QUEUE_DEPTH_LOG2-1:0] rd_ptr;
  logic [QUEUE_DEPTH_LOG2:0]   count;
  logic [3:0]                  step;
  op_t                         cur;
  logic                        take;
  logic                        done;

  // Input side stops with room for the in-flight parser stage.
  assign full  = (count >= 5'(DEPTH - 2));
  assign empty = (count == '0);
  assign cur   = mem[rd_ptr];

  // Current operation expands into one or more words.
  always_comb begin
    result = '0;
    done   = 1'b1;
    case (cur.op)
      OP_STATUS: begin
        result.kind = cur.flag ? KIND_REJECT : KIND_ACCEPT;
        result.last = cur.flag;
      end
      OP_WINDOW: begin
        done = 1'b0;
        case (step)
          4'd0: begin result.kind = KIND_CMD;  result.word_value = CMD_HADDR; end
          4'd1: begin result.kind = KIND_DATA; result.word_value = cur.val_a; end
          4'd2: begin result.kind = KIND_CMD;  result.word_value = CMD_VEND;  end
          4'd3: begin result.kind = KIND_DATA; result.word_value = cur.val_b; end
          4'd4: begin result.kind = KIND_CMD;  result.word_value = CMD_VSTA;  end
          4'd5: begin result.kind = KIND_DATA; result.word_value = cur.val_b; end
          4'd6: begin result.kind = KIND_CMD;  result.word_value = CMD_XADDR; end
          4'd7: begin result.kind = KIND_DATA; result.word_value = cur.val_c; end
          4'd8: begin result.kind = KIND_CMD;  result.word_value = CMD_YADDR; end
          4'd9: begin result.kind = KIND_DATA; result.word_value = cur.val_b; end
          default: begin
            result.kind = KIND_CMD;
            result.word_value = CMD_WRAM;
            done = 1'b1;
          end
        endcase
      end
      default: begin
        result.kind       = KIND_DATA;
        result.word_value = cur.val_a;
        result.last       = cur.flag;
      end
    endcase
  end

  assign take = pop && !empty;

  // Queue pointers and word step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      step   <= 4'd0;
    end else begin
      if (op_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        if (done) begin
          rd_ptr <= rd_ptr + 1'b1;
          step   <= 4'd0;
        end else begin
          step <= step + 4'd1;
        end
      end
      count <= count + {4'd0, op_valid} - {4'd0, take && done};
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      mem[wr_ptr] <= op;
    end
  end

endmodule

// ===== hdl/bmp24_to_lcd_rgb565_streamer_core.sv =====
// ----------------------------------------------------------------------------
// 24-bit BMP to RGB565 LCD streamer
// Parses a BMP byte stream and emits LCD window commands and pixel words.
//
//   channel | direction | handshake    | word
//   in      | input     | push / full  | in_word_t  (data_byte, file_start)
//   out     | output    | empty / pop  | out_word_t (kind, word_value, last)
//
// One file byte can be taken every cycle unless full. A row start expands into
// eleven output words, drained one per cycle from a sixteen-entry operation queue,
// which is what bounds sustained input on narrow images. Reset is synchronous and
// clears the parser and the queue. Either side may stall independently.
// ----------------------------------------------------------------------------
module bmp24_to_lcd_rgb565_streamer_core import bmp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int unsigned COLUMN_OFFSET   = DEF_COLUMN_OFFSET,
  parameter int unsigned ROW_OFFSET      = DEF_ROW_OFFSET,
  parameter int unsigned MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic op_valid;
  op_t  op;

  // Front end parser.
  bmp_parse #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .COLUMN_OFFSET  (COLUMN_OFFSET),
    .ROW_OFFSET     (ROW_OFFSET),
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_valid(push && !full),
    .in_word (in_word),
    .op_valid(op_valid),
    .op      (op)
  );

  // Back end word emitter.
  bmp_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .op_valid(op_valid),
    .op      (op),
    .full    (full),
    .empty   (empty),
    .result  (result),
    .pop     (pop)
  );

  // Reject status always closes its stream.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_REJECT) |-> result.last)
    else $error("reject status without last");

  // No parser output is produced while reset is held.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !op_valid)
    else $error("operation issued out of reset");

  // Words from the queue hold while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("queued word changed while stalled");

endmodule
